@@ sv/tdp_pkg.sv @@
// tdp_pkg: shared constants and types for the trial-division prime test.
// No dependencies; used by tdp_divider and trial_division_prime_test.

package tdp_pkg;

	localparam int WIDTH = 32;            // tested width, 2..64
	localparam int CNT_W = $clog2(WIDTH); // divider step counter width

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_EVAL
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ sv/trial_division_prime_test.sv @@
// trial_division_prime_test: top level, sequencer around one shared serial divider.
// Depends on tdp_pkg and tdp_divider.
//
//  channel | signals                       | transfer when
//  --------+-------------------------------+-------------------------
//  input   | in_valid, in_ready, number    | in_valid && in_ready
//  output  | out_valid, out_ready, is_prime| out_valid && out_ready
//
// Each trial divisor d = 2, 3, ... runs the divider steps, waits for its done pulse
// and then passes the evaluate state; one division yields both n / d (bound
// check d <= n / d) and n % d. Numbers below two skip the divider and go
// straight to the evaluate state. in_ready is high only when idle.
// A result waits in the output register; a stalled output holds the sequencer
// in its evaluate state. Reset clears control state only.

module trial_division_prime_test (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_prime
);

	tdp_pkg::state_t state_q, state_nxt;

	logic [tdp_pkg::WIDTH-1:0] n_q;
	logic [tdp_pkg::WIDTH-1:0] n_in;
	logic [tdp_pkg::WIDTH-1:0] d_q;
	logic [tdp_pkg::WIDTH-1:0] d_nxt;
	logic                      small_q;
	logic                      out_valid_q;
	logic                      is_prime_q;

	tdp_pkg::div_ctrl_t        div_ctrl;
	tdp_pkg::div_stat_t        div_stat;
	logic [tdp_pkg::WIDTH-1:0] quot;
	logic [tdp_pkg::WIDTH-1:0] rem;
	logic [tdp_pkg::WIDTH-1:0] dividend_sel;

	logic accept;
	logic in_small;
	logic out_free;
	logic decided;
	logic res;
	logic load_out;
	logic d_inc;

	assign n_in     = tdp_pkg::WIDTH'(number);
	assign in_small = (n_in < tdp_pkg::WIDTH'(2));
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// dividend is the incoming number on the accept cycle, else the held one
	assign dividend_sel = accept ? n_in : n_q;

	// decision in evaluate state
	always_comb begin
		decided = 1'b1;
		res     = 1'b0;
		if (small_q) begin
			res = 1'b0;
		end else if (quot < d_q) begin
			res = 1'b1;
		end else if (rem == '0) begin
			res = 1'b0;
		end else begin
			decided = 1'b0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tdp_pkg::S_IDLE: begin
				if (accept) begin
					state_nxt = in_small ? tdp_pkg::S_EVAL : tdp_pkg::S_DIV;
				end
			end
			tdp_pkg::S_DIV: begin
				if (div_stat.done) begin
					state_nxt = tdp_pkg::S_EVAL;
				end
			end
			tdp_pkg::S_EVAL: begin
				if (!decided) begin
					state_nxt = tdp_pkg::S_DIV;
				end else if (out_free) begin
					state_nxt = tdp_pkg::S_IDLE;
				end
			end
			default: state_nxt = tdp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		div_ctrl.start = 1'b0;
		load_out       = 1'b0;
		d_inc          = 1'b0;
		case (state_q)
			tdp_pkg::S_IDLE: begin
				in_ready       = 1'b1;
				div_ctrl.start = in_valid && !in_small;
			end
			tdp_pkg::S_EVAL: begin
				if (!decided) begin
					d_inc          = 1'b1;
					div_ctrl.start = 1'b1;
				end else begin
					load_out = out_free;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (accept) begin
			d_nxt = tdp_pkg::WIDTH'(2);
		end else if (d_inc) begin
			d_nxt = d_q + 1'b1;
		end else begin
			d_nxt = d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tdp_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		d_q <= d_nxt;
		if (accept) begin
			n_q     <= n_in;
			small_q <= in_small;
		end
		if (load_out) begin
			is_prime_q <= res;
		end
	end

	tdp_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (dividend_sel),
		.divisor  (d_nxt),
		.stat     (div_stat),
		.quotient (quot),
		.remainder(rem)
	);

	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("accepted a transfer but stayed ready");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == tdp_pkg::S_DIV))
		else $error("divider finished outside divide state");

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctrl.start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	a_div_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tdp_pkg::S_DIV) |-> (d_q >= tdp_pkg::WIDTH'(2)))
		else $error("trial divisor below two");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("result load lost");

endmodule

@@ sv/tdp_divider.sv @@
// tdp_divider: restoring divider, one quotient bit per cycle.
// Depends on tdp_pkg. Latches operands at start; done pulses when quotient and remainder hold.

module tdp_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tdp_pkg::div_ctrl_t          ctrl,
	input  logic [tdp_pkg::WIDTH-1:0]   dividend,
	input  logic [tdp_pkg::WIDTH-1:0]   divisor,
	output tdp_pkg::div_stat_t          stat,
	output logic [tdp_pkg::WIDTH-1:0]   quotient,
	output logic [tdp_pkg::WIDTH-1:0]   remainder
);

	logic [tdp_pkg::WIDTH-1:0] acc_q;
	logic [tdp_pkg::WIDTH-1:0] qr_q;
	logic [tdp_pkg::WIDTH-1:0] dvs_q;
	logic [tdp_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;

	logic [tdp_pkg::WIDTH:0] trial;
	logic [tdp_pkg::WIDTH:0] diff;
	logic                    qbit;

	assign trial = {acc_q, qr_q[tdp_pkg::WIDTH-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = ~diff[tdp_pkg::WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= tdp_pkg::CNT_W'(tdp_pkg::WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			acc_q <= '0;
			qr_q  <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			acc_q <= qbit ? diff[tdp_pkg::WIDTH-1:0] : trial[tdp_pkg::WIDTH-1:0];
			qr_q  <= {qr_q[tdp_pkg::WIDTH-2:0], qbit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = qr_q;
	assign remainder = acc_q;

endmodule

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking testbench for trial_division_prime_test.
// Depends on tdp_pkg and trial_division_prime_test; predicts each verdict by trial division.
`timescale 1ns / 1ps

module tb_top;

	localparam int WATCHDOG_LIMIT = 600000;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		logic [31:0] number;
		logic        is_prime;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] number;
	logic        out_valid;
	logic        out_ready;
	logic        is_prime;

	verdict_t    pending_verdicts[$];
	int          mismatches;
	int          idle_cycles;
	bit          no_idle;

	trial_division_prime_test uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.number    (number),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.is_prime  (is_prime)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic prime_by_division(input logic [31:0] n);
		longint unsigned mask;
		longint unsigned v;
		longint unsigned d;
		mask = ((64'd1 << (tdp_pkg::WIDTH - 1)) << 1) - 64'd1;
		v = longint'(n) & mask;
		if (v < 2)
			return 1'b0;
		for (d = 2; d <= v / d; d++)
			if (v % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	// one transfer on the input channel; drops in_valid at the falling edge after acceptance
	task automatic send_number(input logic [31:0] n);
		verdict_t v;
		@(negedge clk);
		if (!no_idle) begin
			while ($urandom_range(99) < 30) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		number   <= n;
		do
			@(posedge clk);
		while (!in_ready);
		v.number   = n;
		v.is_prime = prime_by_division(n);
		pending_verdicts.push_back(v);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_below_two();
		send_number(32'd0);
		send_number(32'd1);
		send_number(32'd2);
		send_number(32'd3);
		send_number(32'd4);
		send_number(32'd5);
	endtask

	task automatic test_square_bounds();
		send_number(32'd9);
		send_number(32'd25);
		send_number(32'd49);
		send_number(32'd63001);
		send_number(32'd65521);
		send_number(32'd65536);
		send_number(32'd1048573);
	endtask

	task automatic test_wide_values();
		send_number(32'hFFFF_FFFF);
		send_number(32'hFFFF_FFFE);
		send_number(32'h8000_0000);
		send_number(32'hAAAA_AAAA);
		send_number(32'h5555_5555);
		send_number(32'hFFFE_0001);
		send_number(32'd16777213);
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		for (int i = 0; i < 20; i++)
			send_number($urandom_range(0, 1023));
		no_idle = 1'b0;
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 4; i++)
			send_number($urandom_range(0, 255));
		wait_drained();
		for (int i = 0; i < 4; i++)
			send_number($urandom_range(0, 255));
	endtask

	task automatic test_random_numbers();
		logic [31:0] n;
		int          pick;
		for (int i = 0; i < 52; i++) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				n = $urandom_range(0, 4095);
			end else if (pick < 80) begin
				n = $urandom_range(0, 1048575);
			end else if (pick < 90) begin
				n = $urandom() & 32'hFFFF_FFFE;
			end else begin
				n = $urandom();
				n = n - (n % 3);
			end
			send_number(n);
		end
	endtask

	always @(negedge clk)
		out_ready <= no_idle || ($urandom_range(99) >= 30);

	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result is_prime=%0b", is_prime);
			end else begin
				v = pending_verdicts.pop_front();
				if (is_prime !== v.is_prime) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("number %0d: expected is_prime=%0b, got %0b",
							v.number, v.is_prime, is_prime);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		number      = '0;
		out_ready   = 1'b0;
		mismatches  = 0;
		idle_cycles = 0;
		no_idle     = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_below_two();
		test_square_bounds();
		test_wide_values();
		test_back_to_back();
		test_drain_pause();
		test_random_numbers();

		wait_drained();
		repeat (80) @(posedge clk);
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
